>>> rtl/wsq_pkg.sv
// Shared types, wave tables and fixed-point constants for the water surface query core.
// Self-contained; the top level, wsq_sine and wsq_cell refer to it by scoped names.
`default_nettype none

package wsq_pkg;

	localparam int MAX_SLOTS = 16;
	localparam int SUM_W     = 48;
	localparam int CELL_LAT  = 11;
	localparam int SQ_W      = 62;
	localparam int LEN_W     = 31;
	localparam int DIV_N_W   = 46;
	localparam int DIV_Q_W   = 15;

	localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
	localparam logic [14:0] NORM_ONE = 15'd16384;

	// Sine polynomial in Horner form, innermost coefficient first.
	localparam int unsigned POLY_TOP = 172272;
	localparam int unsigned POLY_C [4] = '{5026995, 85569306, 693598668, 1686629713};

	// Direction over wavelength, Q32 turns per metre.
	localparam int KX_TAB [MAX_SLOTS] = '{73482667, 25501368, 24494222, 14077948, 8164741,
		2352953, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
	localparam int KZ_TAB [MAX_SLOTS] = '{51079411, 36775657, 17026470, 4921317, 5675490,
		2333069, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
	// Temporal frequency, Q30 turns per second.
	localparam int FQ_TAB [MAX_SLOTS] = '{284669788, 201291937, 164354179, 116215954, 94889929,
		54784726, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
	// Seed phase, Q24 turns.
	localparam int SEED_TAB [MAX_SLOTS] = '{10358802, 2867471, 2516193, 1813639, 759806,
		10786415, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
	// Amplitude, Q16 metres.
	localparam int AMP_TAB [MAX_SLOTS] = '{10486, 8389, 14156, 11010, 17302, 19923,
		0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
	// Slope gains, Q30.
	localparam int GX_TAB [MAX_SLOTS] = '{18468209, 5127354, 8310687, 3715083, 3385841,
		1123587, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
	localparam int GZ_TAB [MAX_SLOTS] = '{12837657, 7394185, 5776946, 1298705, 2353567,
		1114092, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
	// Drift gains, Q24 m/s.
	localparam int VX_TAB [MAX_SLOTS] = '{2337801, 2294738, 4049189, 6582499, 7013405,
		10502230, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
	localparam int VZ_TAB [MAX_SLOTS] = '{1625056, 3309254, 2814682, 2301086, 4875170,
		10413479, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

	typedef struct packed {
		logic signed [31:0] world_x;
		logic signed [31:0] world_z;
		logic        [31:0] time_s;
	} wsq_in_t;

	typedef struct packed {
		logic signed [23:0] surface_height;
		logic signed [15:0] normal_x;
		logic        [14:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [15:0] drift_vel_x;
		logic signed [15:0] drift_vel_z;
		logic        [15:0] roughness;
	} wsq_out_t;

	// Record handed from one wave cell to the next.
	typedef struct packed {
		logic signed [31:0]      px;
		logic signed [31:0]      pz;
		logic        [31:0]      t;
		logic signed [SUM_W-1:0] hs;
		logic signed [SUM_W-1:0] sxs;
		logic signed [SUM_W-1:0] szs;
		logic signed [SUM_W-1:0] vxs;
		logic signed [SUM_W-1:0] vzs;
	} link_t;

	typedef struct packed {
		logic [1:0]  q;
		logic [30:0] x;
		logic [30:0] y;
		logic [30:0] r;
	} trig_t;

	typedef struct packed {
		logic signed [23:0] h;
		logic signed [15:0] vx;
		logic signed [15:0] vz;
		logic        [29:0] ax;
		logic        [29:0] az;
		logic               negx;
		logic               negz;
	} side_t;

endpackage

`default_nettype wire

>>> rtl/water_surface_wave_query_core.sv
// Top level of the water surface query core: wave cell chain and normal/roughness back end.
// Depends on wsq_pkg, wsq_cell, wsq_sine, wsq_isqrt and wsq_div.
`default_nettype none

// The core answers point queries on a sum-of-sines water surface. A query transaction is
// taken at every rising edge where start is high and busy is low; busy is never raised, so
// a new query may be presented in every cycle and the core sustains one query per clock.
// Each query yields exactly one result transaction: result holds the height, unit normal,
// drift velocity and roughness, and done is high for exactly one cycle while it is valid.
// The receiver cannot hold results off, and none is needed, since nothing inside waits.
// The pipeline is a chain of wave cells, 11 stages each, followed by a 31-stage square
// root, a 15-stage divider for the normal components and stages of rounding and
// squaring around them.
// sea_level is written through cfg_we and cfg_wdata and should only change while no query
// is in flight. The asynchronous reset clears sea_level to zero and empties the pipeline,
// so no result strobe appears for queries that were in flight when reset was asserted.
module water_surface_wave_query_core #(
	parameter int NUM_WAVES  = 6,
	parameter int PHASE_BITS = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire wsq_pkg::wsq_in_t   query,
	input  wire logic               cfg_we,
	input  wire logic signed [23:0] cfg_wdata,
	output logic                    done,
	output wsq_pkg::wsq_out_t       result
);

	localparam int SQ_LAT    = wsq_pkg::SQ_W / 2;
	localparam int DIV_LAT   = wsq_pkg::DIV_Q_W;
	localparam int SIDE_N    = 3 + SQ_LAT + 1 + DIV_LAT;
	localparam int G_IDX     = 3 + SQ_LAT;
	localparam int TOTAL_LAT = wsq_pkg::CELL_LAT * NUM_WAVES + SIDE_N + 1;

	function automatic logic signed [47:0] rnd_shift(input logic signed [47:0] v,
		input int unsigned n);
		logic [47:0] mag;
		logic [47:0] r;
		mag = v[47] ? 48'(-v) : 48'(v);
		r   = (mag + (48'(1) << (n - 1))) >> n;
		return v[47] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
		if (v > 48'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (v < -48'sd8388608) begin
			return 24'sh800000;
		end
		return v[23:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
		if (v > 48'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -48'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	// Configuration register.
	logic signed [23:0] sea_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sea_level_q <= '0;
		end else if (cfg_we) begin
			sea_level_q <= cfg_wdata;
		end
	end

	assign busy = 1'b0;

	// Chain of wave cells. Each cell adds its component to the running sums and hands the
	// query point on to its neighbour, so every cell works on a different query at once.
	wsq_pkg::link_t links [NUM_WAVES+1];
	logic [NUM_WAVES:0] lvld;

	assign lvld[0]      = start && !busy;
	assign links[0].px  = query.world_x;
	assign links[0].pz  = query.world_z;
	assign links[0].t   = query.time_s;
	assign links[0].hs  = '0;
	assign links[0].sxs = '0;
	assign links[0].szs = '0;
	assign links[0].vxs = '0;
	assign links[0].vzs = '0;

	for (genvar i = 0; i < NUM_WAVES; i++) begin : g_cell
		wsq_cell #(.IDX(i), .PHASE_BITS(PHASE_BITS)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.vld_in   (lvld[i]),
			.link_in  (links[i]),
			.vld_out  (lvld[i+1]),
			.link_out (links[i+1])
		);
	end

	// Back end. Side data travels in a delay line aligned with the square root and divider.
	wsq_pkg::side_t side_q [SIDE_N];
	logic [SIDE_N-1:0] vld_q;
	wsq_pkg::side_t side_in;
	logic signed [47:0] sx, sz;

	always_comb begin
		sx = rnd_shift(links[NUM_WAVES].sxs, 16);
		sz = rnd_shift(links[NUM_WAVES].szs, 16);
		side_in.h    = sat24(rnd_shift(links[NUM_WAVES].hs, 24) + 48'(sea_level_q));
		side_in.vx   = sat16(rnd_shift(links[NUM_WAVES].vxs, 28));
		side_in.vz   = sat16(rnd_shift(links[NUM_WAVES].vzs, 28));
		side_in.ax   = sx[47] ? 30'(-sx) : 30'(sx);
		side_in.az   = sz[47] ? 30'(-sz) : 30'(sz);
		side_in.negx = !sx[47] && (sx != 48'sd0);
		side_in.negz = !sz[47] && (sz != 48'sd0);
	end

	always_ff @(posedge clk) begin
		side_q[0] <= side_in;
		for (int i = 1; i < SIDE_N; i++) begin
			side_q[i] <= side_q[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[SIDE_N-2:0], lvld[NUM_WAVES]};
		end
	end

	// Squared slope magnitude, then the two square-root radicands.
	logic [59:0] sqx_s2, sqz_s2;
	logic [wsq_pkg::SQ_W-1:0] rad_len_s3, rad_rgh_s3;

	always_ff @(posedge clk) begin
		sqx_s2     <= side_q[0].ax * side_q[0].ax;
		sqz_s2     <= side_q[0].az * side_q[0].az;
		rad_rgh_s3 <= 62'(sqx_s2) + 62'(sqz_s2);
		rad_len_s3 <= (62'(1) << 60) + 62'(sqx_s2) + 62'(sqz_s2);
	end

	logic [wsq_pkg::LEN_W-1:0] root_len, root_rgh;

	wsq_isqrt #(.IN_W(wsq_pkg::SQ_W)) u_sqrt_len (
		.clk      (clk),
		.rad_in   (rad_len_s3),
		.root_out (root_len)
	);

	wsq_isqrt #(.IN_W(wsq_pkg::SQ_W)) u_sqrt_rgh (
		.clk      (clk),
		.rad_in   (rad_rgh_s3),
		.root_out (root_rgh)
	);

	// Rounded quotients by the normal length: numerators carry half the divisor.
	logic [wsq_pkg::DIV_N_W-1:0] numx_q, numz_q, numy_q;
	logic [wsq_pkg::LEN_W-1:0]   den_q;
	logic [15:0]                 rough_q [DIV_LAT+1];
	logic [31:0]                 rgh_sum;

	assign rgh_sum = {1'b0, root_rgh} + 32'd32768;

	always_ff @(posedge clk) begin
		den_q  <= root_len;
		numx_q <= (46'(side_q[G_IDX-1].ax) << 14) + 46'(root_len[wsq_pkg::LEN_W-1:1]);
		numz_q <= (46'(side_q[G_IDX-1].az) << 14) + 46'(root_len[wsq_pkg::LEN_W-1:1]);
		numy_q <= (46'(1) << 44) + 46'(root_len[wsq_pkg::LEN_W-1:1]);
		rough_q[0] <= rgh_sum[31:16];
		for (int i = 1; i <= DIV_LAT; i++) begin
			rough_q[i] <= rough_q[i-1];
		end
	end

	logic [wsq_pkg::DIV_Q_W-1:0] qx, qz, qy;

	wsq_div #(.N_W(wsq_pkg::DIV_N_W), .D_W(wsq_pkg::LEN_W), .Q_W(wsq_pkg::DIV_Q_W)) u_div_x (
		.clk (clk), .num_in (numx_q), .den_in (den_q), .quo_out (qx)
	);

	wsq_div #(.N_W(wsq_pkg::DIV_N_W), .D_W(wsq_pkg::LEN_W), .Q_W(wsq_pkg::DIV_Q_W)) u_div_z (
		.clk (clk), .num_in (numz_q), .den_in (den_q), .quo_out (qz)
	);

	wsq_div #(.N_W(wsq_pkg::DIV_N_W), .D_W(wsq_pkg::LEN_W), .Q_W(wsq_pkg::DIV_Q_W)) u_div_y (
		.clk (clk), .num_in (numy_q), .den_in (den_q), .quo_out (qy)
	);

	// Output register. The normal points against the slope, so a positive slope gives a
	// negative component.
	logic [14:0] mx, mz, my;
	wsq_pkg::wsq_out_t result_q;
	logic done_q;

	always_comb begin
		mx = (qx > wsq_pkg::NORM_ONE) ? wsq_pkg::NORM_ONE : qx;
		mz = (qz > wsq_pkg::NORM_ONE) ? wsq_pkg::NORM_ONE : qz;
		my = (qy > wsq_pkg::NORM_ONE) ? wsq_pkg::NORM_ONE : qy;
	end

	always_ff @(posedge clk) begin
		result_q.surface_height <= side_q[SIDE_N-1].h;
		result_q.normal_x       <= side_q[SIDE_N-1].negx ? -$signed(16'(mx)) : $signed(16'(mx));
		result_q.normal_z       <= side_q[SIDE_N-1].negz ? -$signed(16'(mz)) : $signed(16'(mz));
		result_q.normal_y       <= my;
		result_q.drift_vel_x    <= side_q[SIDE_N-1].vx;
		result_q.drift_vel_z    <= side_q[SIDE_N-1].vz;
		result_q.roughness      <= rough_q[DIV_LAT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_q[SIDE_N-1];
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// Every accepted query produces its strobe once it has passed the whole pipeline, and only then.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##TOTAL_LAT done)
		else $error("result strobe missing after accepted query");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, TOTAL_LAT))
		else $error("result strobe without a matching query");

	a_normal_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.normal_y <= wsq_pkg::NORM_ONE && result.normal_y != 15'd0)
		else $error("normal_y outside its range");

	// A flat surface must give the straight-up normal.
	a_flat_normal: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.roughness == 16'd0 |->
			result.normal_y == wsq_pkg::NORM_ONE && result.normal_x == 16'sd0 &&
			result.normal_z == 16'sd0)
		else $error("flat surface with tilted normal");

endmodule

`default_nettype wire

>>> rtl/wsq_sine.sv
// Pipelined sine of a phase in turns, Q16 result, seven register stages.
// Depends on wsq_pkg for the polynomial constants and the stage record.
`default_nettype none

module wsq_sine #(
	parameter int PHASE_BITS = 24
) (
	input  wire logic                  clk,
	input  wire logic [PHASE_BITS-1:0] phase_in,
	output logic signed [17:0]         sine_out
);

	wsq_pkg::trig_t st_q [6];
	logic [29:0] frac30;
	logic [30:0] x_in;
	logic [61:0] sq;

	always_comb begin
		frac30 = 30'(phase_in[PHASE_BITS-3:0]) << (32 - PHASE_BITS);
		if (phase_in[PHASE_BITS-2]) begin
			x_in = wsq_pkg::ONE_Q30 - {1'b0, frac30};
		end else begin
			x_in = {1'b0, frac30};
		end
	end

	assign sq = st_q[0].x * st_q[0].x;

	always_ff @(posedge clk) begin
		st_q[0].q <= phase_in[PHASE_BITS-1:PHASE_BITS-2];
		st_q[0].x <= x_in;
		st_q[0].y <= '0;
		st_q[0].r <= '0;
		st_q[1].q <= st_q[0].q;
		st_q[1].x <= st_q[0].x;
		st_q[1].y <= sq[60:30];
		st_q[1].r <= 31'(wsq_pkg::POLY_TOP);
	end

	// Horner steps: each stage owns one multiplier.
	for (genvar k = 2; k < 6; k++) begin : g_horner
		logic [61:0] prod;
		assign prod = st_q[k-1].r * st_q[k-1].y;
		always_ff @(posedge clk) begin
			st_q[k].q <= st_q[k-1].q;
			st_q[k].x <= st_q[k-1].x;
			st_q[k].y <= st_q[k-1].y;
			st_q[k].r <= 31'(32'(wsq_pkg::POLY_C[k-2]) - prod[61:30]);
		end
	end

	logic [61:0] sp;
	logic [32:0] s33;
	logic [16:0] mag;

	always_comb begin
		sp  = st_q[5].r * st_q[5].x;
		s33 = {1'b0, sp[61:30]} + 33'd8192;
		if (s33[32:14] > 19'd65536) begin
			mag = 17'd65536;
		end else begin
			mag = s33[30:14];
		end
	end

	always_ff @(posedge clk) begin
		if (st_q[5].q[1]) begin
			sine_out <= -$signed({1'b0, mag});
		end else begin
			sine_out <= $signed({1'b0, mag});
		end
	end

endmodule

`default_nettype wire

>>> rtl/wsq_cell.sv
// One wave cell: phase, sine and cosine of its component, and its share of the sums.
// Depends on wsq_pkg and wsq_sine; cells are chained by the top level.
`default_nettype none

module wsq_cell #(
	parameter int IDX        = 0,
	parameter int PHASE_BITS = 24
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           vld_in,
	input  wire wsq_pkg::link_t link_in,
	output logic                vld_out,
	output wsq_pkg::link_t      link_out
);

	localparam int LAST = wsq_pkg::CELL_LAT - 1;
	localparam logic signed [27:0] KX_C   = 28'(wsq_pkg::KX_TAB[IDX]);
	localparam logic signed [27:0] KZ_C   = 28'(wsq_pkg::KZ_TAB[IDX]);
	localparam logic        [28:0] FQ_C   = 29'(wsq_pkg::FQ_TAB[IDX]);
	localparam logic        [23:0] SEED_C = 24'(wsq_pkg::SEED_TAB[IDX]);
	localparam logic signed [15:0] AMP_C  = 16'(wsq_pkg::AMP_TAB[IDX]);
	localparam logic signed [25:0] GX_C   = 26'(wsq_pkg::GX_TAB[IDX]);
	localparam logic signed [25:0] GZ_C   = 26'(wsq_pkg::GZ_TAB[IDX]);
	localparam logic signed [24:0] VX_C   = 25'(wsq_pkg::VX_TAB[IDX]);
	localparam logic signed [24:0] VZ_C   = 25'(wsq_pkg::VZ_TAB[IDX]);
	localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);

	logic [wsq_pkg::CELL_LAT-1:0] vld_q;
	wsq_pkg::link_t link_q [wsq_pkg::CELL_LAT];

	logic signed [59:0] mx_full, mz_full;
	logic        [60:0] mt_full;
	logic [39:0] mx_s1, mz_s1, mt_s1;
	logic [39:0] ph;
	logic [PHASE_BITS-1:0] p_s2;
	logic signed [17:0] sn_s9, cs_s9;
	logic signed [33:0] hp_s10;
	logic signed [43:0] gxp_s10, gzp_s10;
	logic signed [42:0] vxp_s10, vzp_s10;

	assign mx_full = link_in.px * KX_C;
	assign mz_full = link_in.pz * KZ_C;
	assign mt_full = link_in.t * FQ_C;
	// Phase only matters modulo one turn, so 40 bits of the Q40 sum suffice.
	assign ph = mx_s1 + mz_s1 - mt_s1 + {SEED_C, 16'h0000};

	always_ff @(posedge clk) begin
		mx_s1 <= mx_full[39:0];
		mz_s1 <= mz_full[39:0];
		mt_s1 <= mt_full[39:0];
		p_s2  <= ph[39 -: PHASE_BITS];
	end

	wsq_sine #(.PHASE_BITS(PHASE_BITS)) u_sin (
		.clk      (clk),
		.phase_in (p_s2),
		.sine_out (sn_s9)
	);

	wsq_sine #(.PHASE_BITS(PHASE_BITS)) u_cos (
		.clk      (clk),
		.phase_in (p_s2 + QUARTER),
		.sine_out (cs_s9)
	);

	always_ff @(posedge clk) begin
		hp_s10  <= AMP_C * sn_s9;
		gxp_s10 <= GX_C * cs_s9;
		gzp_s10 <= GZ_C * cs_s9;
		vxp_s10 <= VX_C * sn_s9;
		vzp_s10 <= VZ_C * sn_s9;
	end

	always_ff @(posedge clk) begin
		link_q[0] <= link_in;
		for (int i = 1; i < LAST; i++) begin
			link_q[i] <= link_q[i-1];
		end
		link_q[LAST].px  <= link_q[LAST-1].px;
		link_q[LAST].pz  <= link_q[LAST-1].pz;
		link_q[LAST].t   <= link_q[LAST-1].t;
		link_q[LAST].hs  <= link_q[LAST-1].hs  + 48'(hp_s10);
		link_q[LAST].sxs <= link_q[LAST-1].sxs + 48'(gxp_s10);
		link_q[LAST].szs <= link_q[LAST-1].szs + 48'(gzp_s10);
		link_q[LAST].vxs <= link_q[LAST-1].vxs + 48'(vxp_s10);
		link_q[LAST].vzs <= link_q[LAST-1].vzs + 48'(vzp_s10);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[wsq_pkg::CELL_LAT-2:0], vld_in};
		end
	end

	assign vld_out  = vld_q[LAST];
	assign link_out = link_q[LAST];

endmodule

`default_nettype wire

>>> rtl/wsq_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Self-contained apart from the house style; used twice by the top level.
`default_nettype none

module wsq_isqrt #(
	parameter int IN_W = 62
) (
	input  wire logic              clk,
	input  wire logic [IN_W-1:0]   rad_in,
	output logic      [IN_W/2-1:0] root_out
);

	localparam int STAGES = IN_W / 2;

	logic [IN_W-1:0] rem_q  [STAGES];
	logic [IN_W-1:0] root_q [STAGES];

	for (genvar j = 0; j < STAGES; j++) begin : g_stage
		localparam logic [IN_W-1:0] BITV = IN_W'(1) << (2 * (STAGES - 1 - j));
		logic [IN_W-1:0] rem_i, root_i, trial;
		if (j == 0) begin : g_first
			assign rem_i  = rad_in;
			assign root_i = '0;
		end else begin : g_next
			assign rem_i  = rem_q[j-1];
			assign root_i = root_q[j-1];
		end
		assign trial = root_i + BITV;
		always_ff @(posedge clk) begin
			if (rem_i >= trial) begin
				rem_q[j]  <= rem_i - trial;
				root_q[j] <= (root_i >> 1) + BITV;
			end else begin
				rem_q[j]  <= rem_i;
				root_q[j] <= root_i >> 1;
			end
		end
	end

	assign root_out = root_q[STAGES-1][IN_W/2-1:0];

endmodule

`default_nettype wire

>>> rtl/wsq_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Self-contained apart from the house style; the quotient must fit Q_W bits.
`default_nettype none

module wsq_div #(
	parameter int N_W = 46,
	parameter int D_W = 31,
	parameter int Q_W = 15
) (
	input  wire logic           clk,
	input  wire logic [N_W-1:0] num_in,
	input  wire logic [D_W-1:0] den_in,
	output logic      [Q_W-1:0] quo_out
);

	logic [N_W-1:0] rem_q [Q_W];
	logic [D_W-1:0] den_q [Q_W];
	logic [Q_W-1:0] quo_q [Q_W];

	for (genvar j = 0; j < Q_W; j++) begin : g_stage
		localparam int SH = Q_W - 1 - j;
		logic [N_W-1:0] rem_i, dsh;
		logic [D_W-1:0] den_i;
		logic [Q_W-1:0] quo_i;
		if (j == 0) begin : g_first
			assign rem_i = num_in;
			assign den_i = den_in;
			assign quo_i = '0;
		end else begin : g_next
			assign rem_i = rem_q[j-1];
			assign den_i = den_q[j-1];
			assign quo_i = quo_q[j-1];
		end
		assign dsh = N_W'(den_i) << SH;
		always_ff @(posedge clk) begin
			den_q[j] <= den_i;
			if (rem_i >= dsh) begin
				rem_q[j] <= rem_i - dsh;
				quo_q[j] <= quo_i | (Q_W'(1) << SH);
			end else begin
				rem_q[j] <= rem_i;
				quo_q[j] <= quo_i;
			end
		end
	end

	assign quo_out = quo_q[Q_W-1];

endmodule

`default_nettype wire

>>> sim/tb_water_surface_wave_query_core.sv
// Self-checking testbench for water_surface_wave_query_core: directed and random point queries.
// Depends on wsq_pkg and the core RTL; prediction is computed here from fixed-point arithmetic.
`default_nettype none

// Scoreboard holding the predicted surface samples in query order.
class surface_scoreboard;
	wsq_pkg::wsq_out_t pending_q[$];
	int errors;

	function void note_query(wsq_pkg::wsq_out_t predicted);
		pending_q.push_back(predicted);
	endfunction

	task check_sample(wsq_pkg::wsq_out_t got);
		wsq_pkg::wsq_out_t want;
		if (pending_q.size() == 0) begin
			mismatch("result with no query outstanding", 0, 0);
			return;
		end
		want = pending_q.pop_front();
		if (got.surface_height !== want.surface_height)
			mismatch("surface_height", got.surface_height, want.surface_height);
		if (got.normal_x !== want.normal_x) mismatch("normal_x", got.normal_x, want.normal_x);
		if (got.normal_y !== want.normal_y) mismatch("normal_y", got.normal_y, want.normal_y);
		if (got.normal_z !== want.normal_z) mismatch("normal_z", got.normal_z, want.normal_z);
		if (got.drift_vel_x !== want.drift_vel_x)
			mismatch("drift_vel_x", got.drift_vel_x, want.drift_vel_x);
		if (got.drift_vel_z !== want.drift_vel_z)
			mismatch("drift_vel_z", got.drift_vel_z, want.drift_vel_z);
		if (got.roughness !== want.roughness)
			mismatch("roughness", got.roughness, want.roughness);
	endtask

	task mismatch(string what, longint got, longint want);
		errors++;
		$display("MISMATCH %s: got %0h expected %0h", what, got, want);
	endtask
endclass

module tb_water_surface_wave_query_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WAVES = 6;
	localparam int PBITS = 24;
	localparam int LATENCY = 11 * WAVES + 51;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	wsq_pkg::wsq_in_t query = '0;
	logic cfg_we = 1'b0;
	logic signed [23:0] cfg_wdata = '0;
	logic done;
	wsq_pkg::wsq_out_t result;

	// The testbench's own copy of the sea level register.
	logic signed [23:0] sea_level_model;

	surface_scoreboard sb;

	always #5 clk = ~clk;

	water_surface_wave_query_core #(.NUM_WAVES(WAVES), .PHASE_BITS(PBITS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .query(query),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .result(result)
	);

	// Results cannot be held off, so every strobed cycle is one result transaction.
	always @(posedge clk)
		if (arst_n && done === 1'b1)
			sb.check_sample(result);

	// Sine of a phase given in turns, Q16, by quadrant fold and a degree 9 polynomial.
	function automatic longint wave_sine(logic [63:0] phase);
		logic [PBITS-1:0] p;
		logic [1:0] quadrant;
		longint x, x2, poly, s;
		p = phase[PBITS-1:0];
		quadrant = p[PBITS-1 -: 2];
		x = longint'(p[PBITS-3:0]) <<< (32 - PBITS);
		if (quadrant[0]) x = (64'sd1 <<< 30) - x;
		x2 = (x * x) >>> 30;
		poly = 172272;
		poly = 5026995 - ((poly * x2) >>> 30);
		poly = 85569306 - ((poly * x2) >>> 30);
		poly = 693598668 - ((poly * x2) >>> 30);
		poly = 1686629713 - ((poly * x2) >>> 30);
		s = (poly * x) >>> 30;
		s = (s + 8192) >>> 14;
		if (s > 65536) s = 65536;
		if (s < 0) s = 0;
		return quadrant[1] ? -s : s;
	endfunction

	// Rounds half away from zero while dropping n fraction bits.
	function automatic longint round_away(longint v, int n);
		longint half;
		half = 64'sd1 <<< (n - 1);
		if (v >= 0) return (v + half) >>> n;
		return -((-v + half) >>> n);
	endfunction

	function automatic longint saturate(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Predicts the complete surface sample for one query at the current sea level.
	function automatic wsq_pkg::wsq_out_t surface_sample(wsq_pkg::wsq_in_t q);
		wsq_pkg::wsq_out_t o;
		logic [63:0] ph, p, ax, az, s2, len;
		longint hsum, sxs, szs, vxs, vzs, sn, cs, sx, sz, nx, nz, ny;
		hsum = 0; sxs = 0; szs = 0; vxs = 0; vzs = 0;
		for (int i = 0; i < WAVES; i++) begin
			ph = 64'(longint'(q.world_x)) * 64'(wsq_pkg::KX_TAB[i])
				+ 64'(longint'(q.world_z)) * 64'(wsq_pkg::KZ_TAB[i])
				- {32'd0, q.time_s} * {32'd0, wsq_pkg::FQ_TAB[i]}
				+ ({32'd0, wsq_pkg::SEED_TAB[i]} << 16);
			p = ph >> (40 - PBITS);
			sn = wave_sine(p);
			cs = wave_sine(p + (64'd1 << (PBITS - 2)));
			hsum += longint'(wsq_pkg::AMP_TAB[i]) * sn;
			sxs += longint'(wsq_pkg::GX_TAB[i]) * cs;
			szs += longint'(wsq_pkg::GZ_TAB[i]) * cs;
			vxs += longint'(wsq_pkg::VX_TAB[i]) * sn;
			vzs += longint'(wsq_pkg::VZ_TAB[i]) * sn;
		end
		o.surface_height = 24'(saturate(round_away(hsum, 24) + longint'(sea_level_model),
			-8388608, 8388607));
		sx = round_away(sxs, 16);
		sz = round_away(szs, 16);
		ax = sx < 0 ? -sx : sx;
		az = sz < 0 ? -sz : sz;
		s2 = ax * ax + az * az;
		len = int_sqrt((64'd1 << 60) + s2);
		if (len == 0) len = 1;
		nx = longint'(((ax << 14) + len / 2) / len);
		nz = longint'(((az << 14) + len / 2) / len);
		if (sx > 0) nx = -nx;
		if (sz > 0) nz = -nz;
		ny = longint'(((64'd1 << 44) + len / 2) / len);
		o.normal_x = 16'(saturate(nx, -16384, 16384));
		o.normal_y = 15'(saturate(ny, 0, 16384));
		o.normal_z = 16'(saturate(nz, -16384, 16384));
		o.drift_vel_x = 16'(saturate(round_away(vxs, 28), -32768, 32767));
		o.drift_vel_z = 16'(saturate(round_away(vzs, 28), -32768, 32767));
		o.roughness = 16'(saturate(longint'((int_sqrt(s2) + 32768) >> 16), 0, 65535));
		return o;
	endfunction

	// Presents one query and holds it until the accepting edge, leaving start high.
	// When no gap is drawn, back-to-back queries keep start high throughout.
	task automatic send_query(wsq_pkg::wsq_in_t q, bit allow_gap);
		int gap;
		gap = allow_gap ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		query <= q;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		sb.note_query(surface_sample(q));
	endtask

	// The sea level may only change with nothing in flight.
	task automatic write_sea_level(logic signed [23:0] level);
		start <= 1'b0;
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= level;
		@(posedge clk);
		cfg_we <= 1'b0;
		sea_level_model = level;
	endtask

	task automatic drain();
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mostly ordinary coordinates and times, with a share of full-range patterns.
	function automatic wsq_pkg::wsq_in_t random_query();
		wsq_pkg::wsq_in_t q;
		case ($urandom_range(0, 3))
			0: begin
				q.world_x = $urandom;
				q.world_z = $urandom;
				q.time_s = $urandom;
			end
			default: begin
				q.world_x = $signed($urandom_range(0, 200000)) - 100000;
				q.world_z = $signed($urandom_range(0, 200000)) - 100000;
				q.time_s = $urandom_range(0, 1 << 22);
			end
		endcase
		return q;
	endfunction

	initial begin
		wsq_pkg::wsq_in_t q;
		logic signed [23:0] levels [5];
		sb = new();
		sea_level_model = '0;
		levels = '{24'sh7FFFFF, -24'sh800000, 24'sd1280, -24'sd5, 24'sd0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes at the reset sea level, including the origin at time zero.
		q = '{32'sd0, 32'sd0, 32'd0};                       send_query(q, 0);
		q = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'hFFFFFFFF}; send_query(q, 0);
		q = '{-32'sh80000000, -32'sh80000000, 32'd0};     send_query(q, 0);
		q = '{-32'sh80000000, 32'sh7FFFFFFF, 32'd1};      send_query(q, 0);
		q = '{32'sd256, -32'sd256, 32'd1024};             send_query(q, 0);
		q = '{32'sh55555555, -32'sh55555555, 32'hAAAAAAAA}; send_query(q, 1);
		q = '{-32'sd1, -32'sd1, 32'h80000000};            send_query(q, 0);

		// The saturating sea levels drive the height to both rails.
		foreach (levels[k]) begin
			write_sea_level(levels[k]);
			for (int n = 0; n < 3; n++) send_query(random_query(), 0);
		end

		// Random part in phases with a new sea level in each; some phases run without gaps.
		for (int phase = 0; phase < 8; phase++) begin
			bit gaps;
			gaps = (phase % 3) != 0;
			for (int n = 0; n < 135; n++) send_query(random_query(), gaps);
			write_sea_level(24'($urandom));
		end

		start <= 1'b0;
		drain();
		repeat (LATENCY + 10) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("tb_water_surface_wave_query_core passed");
		end else begin
			$display("tb_water_surface_wave_query_core failed");
		end
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#5ms;
		$display("tb_water_surface_wave_query_core failed");
		$finish;
	end

endmodule

`default_nettype wire
